### hdl/grid_line_of_sight_walker_macros.svh
// Assertion helpers for the line-of-sight walker.
`ifndef GRID_LINE_OF_SIGHT_WALKER_MACROS_SVH
`define GRID_LINE_OF_SIGHT_WALKER_MACROS_SVH

// Check cons in the same cycle as ante.
`define GLSW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define GLSW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/glsw_pkg.sv
package glsw_pkg;

	localparam int MAP_COLS_DEF    = 64;
	localparam int MAP_ROWS_DEF    = 64;
	localparam int TILE_PIXELS_DEF = 32;

	localparam int XY_W       = 11;
	localparam int TILE_IDX_W = 12;
	localparam int DIV_CYCLES = 2;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_SETUP,
		ST_PREP,
		ST_WALK,
		ST_LAST,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic wr_tile;
		logic load;
		logic div_step;
		logic setup;
		logic prep;
		logic walk_step;
		logic rd_issue;
		logic found_upd;
		logic found_set;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_last;
		logic outside;
		logic walk_end;
		logic wall_hit;
	} sts_t;

endpackage

### hdl/glsw_ram.sv
module glsw_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/glsw_ctrl.sv
module glsw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           func,
	output logic           out_valid,
	input  logic           out_stall,
	input  glsw_pkg::sts_t sts,
	output glsw_pkg::cmd_t cmd
);

	import glsw_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   res_free;

	assign res_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid && func) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_nxt = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_nxt = sts.outside ? ST_FINISH : ST_PREP;
			end
			ST_PREP: begin
				state_nxt = ST_WALK;
			end
			ST_WALK: begin
				if (sts.wall_hit) begin
					state_nxt = ST_FINISH;
				end else if (sts.walk_end) begin
					state_nxt = ST_LAST;
				end
			end
			ST_LAST: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (res_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			ST_IDLE: begin
				cmd.load    = in_valid && func;
				cmd.wr_tile = in_valid && !func;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_SETUP: begin
				cmd.setup     = 1'b1;
				cmd.found_set = sts.outside;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
			end
			ST_WALK: begin
				cmd.rd_issue  = 1'b1;
				cmd.found_upd = 1'b1;
				cmd.walk_step = !sts.wall_hit && !sts.walk_end;
			end
			ST_LAST: begin
				cmd.found_upd = 1'b1;
			end
			ST_FINISH: begin
				cmd.res_load = res_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### hdl/glsw_dp.sv
module glsw_dp #(
	parameter int MAP_COLS    = glsw_pkg::MAP_COLS_DEF,
	parameter int MAP_ROWS    = glsw_pkg::MAP_ROWS_DEF,
	parameter int TILE_PIXELS = glsw_pkg::TILE_PIXELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  glsw_pkg::cmd_t                  cmd,
	output glsw_pkg::sts_t                  sts,
	input  logic [glsw_pkg::TILE_IDX_W-1:0] tile_index,
	input  logic                            tile_is_wall,
	input  logic [glsw_pkg::XY_W-1:0]       start_x,
	input  logic [glsw_pkg::XY_W-1:0]       start_y,
	input  logic [glsw_pkg::XY_W-1:0]       end_x,
	input  logic [glsw_pkg::XY_W-1:0]       end_y,
	output logic                            wall_found
);

	import glsw_pkg::*;

	localparam int MapSize = MAP_COLS * MAP_ROWS;
	localparam int IW      = $clog2(MapSize);
	localparam int RW      = $clog2(TILE_PIXELS);
	localparam int BW      = $clog2((2 ** XY_W) + 2 * TILE_PIXELS);
	localparam int PW      = BW + XY_W;
	localparam int MW      = XY_W + 2;
	localparam int QW      = XY_W + MW;
	localparam int DivSh   = XY_W + RW;

	localparam logic [MW-1:0] RecipM = MW'(((2 ** DivSh) + TILE_PIXELS - 1) / TILE_PIXELS);
	localparam logic [BW-1:0] TBord  = BW'(TILE_PIXELS);
	localparam logic [IW-1:0] LastT  = IW'(MapSize - 1);
	localparam logic [IW-1:0] LastRw = IW'(MapSize - MAP_COLS);
	localparam logic [IW-1:0] ColsI  = IW'(MAP_COLS);

	logic [IW-1:0]        clr_cnt_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 pend_q;
	logic [XY_W-1:0]      dvx_q;
	logic [XY_W-1:0]      dvy_q;
	logic [XY_W-1:0]      qx_q;
	logic [XY_W-1:0]      qy_q;
	logic [RW-1:0]        remx_q;
	logic [RW-1:0]        remy_q;
	logic [XY_W-1:0]      adx_q;
	logic [XY_W-1:0]      ady_q;
	logic                 xdir_q;
	logic                 ydir_q;
	logic [BW-1:0]        bx_q;
	logic [BW-1:0]        by_q;
	logic [PW-1:0]        px_q;
	logic [PW-1:0]        py_q;
	logic [PW-1:0]        incx_q;
	logic [PW-1:0]        incy_q;
	logic [IW-1:0]        cur_q;
	logic                 found_q;
	logic                 wall_found_q;

	logic [QW-1:0]   prodx;
	logic [QW-1:0]   prody;
	logic [XY_W-1:0] quotx;
	logic [XY_W-1:0] quoty;
	logic [RW-1:0]   remx;
	logic [RW-1:0]   remy;
	logic            horiz;
	logic [IW-1:0]   cur_nxt;
	logic            ram_we;
	logic [IW-1:0]   ram_waddr;
	logic            ram_wdata;
	logic            ram_rdata;
	logic            in_range;

	assign prodx = QW'(dvx_q) * QW'(RecipM);
	assign prody = QW'(dvy_q) * QW'(RecipM);
	assign quotx = XY_W'(prodx >> DivSh);
	assign quoty = XY_W'(prody >> DivSh);
	assign remx  = RW'(dvx_q - XY_W'(32'(qx_q) * 32'(TILE_PIXELS)));
	assign remy  = RW'(dvy_q - XY_W'(32'(qy_q) * 32'(TILE_PIXELS)));

	assign horiz = (ady_q == '0) || ((adx_q != '0) && (px_q <= py_q));

	always_comb begin
		cur_nxt = cur_q;
		if (horiz) begin
			if (xdir_q) begin
				cur_nxt = (cur_q == LastT) ? cur_q : cur_q + IW'(1);
			end else begin
				cur_nxt = (cur_q == '0) ? cur_q : cur_q - IW'(1);
			end
		end else begin
			if (ydir_q) begin
				cur_nxt = (cur_q >= LastRw) ? cur_q : cur_q + ColsI;
			end else begin
				cur_nxt = (cur_q < ColsI) ? cur_q : cur_q - ColsI;
			end
		end
	end

	always_comb begin
		sts.clr_last = (clr_cnt_q == LastT);
		sts.div_last = (div_cnt_q == DIV_CNT_W'(DIV_CYCLES - 1));
		sts.outside  = (qx_q >= XY_W'(MAP_COLS)) || (qy_q >= XY_W'(MAP_ROWS));
		sts.walk_end = ((adx_q == '0) && (ady_q == '0)) ||
			(horiz ? (bx_q >= BW'(adx_q)) : (by_q >= BW'(ady_q)));
		sts.wall_hit = pend_q && ram_rdata;
	end

	assign in_range  = (32'(tile_index) < 32'(MapSize));
	assign ram_we    = cmd.clr_wr || (cmd.wr_tile && in_range);
	assign ram_waddr = cmd.clr_wr ? clr_cnt_q : IW'(tile_index);
	assign ram_wdata = cmd.clr_wr ? 1'b0 : tile_is_wall;

	glsw_ram #(
		.WIDTH(1),
		.DEPTH(MapSize)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cur_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			div_cnt_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			pend_q <= cmd.rd_issue;
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + IW'(1);
			end
			if (cmd.load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvx_q   <= start_x;
			dvy_q   <= start_y;
			adx_q   <= (end_x >= start_x) ? end_x - start_x : start_x - end_x;
			ady_q   <= (end_y >= start_y) ? end_y - start_y : start_y - end_y;
			xdir_q  <= (end_x > start_x);
			ydir_q  <= (end_y > start_y);
			found_q <= 1'b0;
		end
		if (cmd.div_step) begin
			if (div_cnt_q == '0) begin
				qx_q <= quotx;
				qy_q <= quoty;
			end else begin
				remx_q <= remx;
				remy_q <= remy;
			end
		end
		if (cmd.setup) begin
			bx_q   <= xdir_q ? TBord - BW'(remx_q) : BW'(remx_q);
			by_q   <= ydir_q ? TBord - BW'(remy_q) : BW'(remy_q);
			incx_q <= PW'(ady_q) * PW'(TILE_PIXELS);
			incy_q <= PW'(adx_q) * PW'(TILE_PIXELS);
			cur_q  <= IW'(32'(qy_q) * 32'(MAP_COLS) + 32'(qx_q));
		end
		if (cmd.prep) begin
			px_q <= PW'(bx_q) * PW'(ady_q);
			py_q <= PW'(by_q) * PW'(adx_q);
		end
		if (cmd.walk_step) begin
			cur_q <= cur_nxt;
			if (horiz) begin
				bx_q <= bx_q + TBord;
				px_q <= px_q + incx_q;
			end else begin
				by_q <= by_q + TBord;
				py_q <= py_q + incy_q;
			end
		end
		if (cmd.found_set) begin
			found_q <= 1'b1;
		end else if (cmd.found_upd) begin
			found_q <= found_q || sts.wall_hit;
		end
		if (cmd.res_load) begin
			wall_found_q <= found_q;
		end
	end

	assign wall_found = wall_found_q;

endmodule

### hdl/grid_line_of_sight_walker.sv
// Write item: taken while idle, no result; writes go back to back.
// Query: steps in order are division, setup, prep, map reads of the tiles visited with
// the start tile, drain and result load; in_stall stays high until the result is loaded.
// A wall ends the walk early; a start off the map skips the walk and answers as blocked.
// Reset: arst_n clears control at once, then a clearing pass over every tile zeroes the
// wall map with in_stall high.
module grid_line_of_sight_walker #(
	parameter int MAP_COLS    = glsw_pkg::MAP_COLS_DEF,
	parameter int MAP_ROWS    = glsw_pkg::MAP_ROWS_DEF,
	parameter int TILE_PIXELS = glsw_pkg::TILE_PIXELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [glsw_pkg::TILE_IDX_W-1:0] tile_index,
	input  logic                            tile_is_wall,
	input  logic [glsw_pkg::XY_W-1:0]       start_x,
	input  logic [glsw_pkg::XY_W-1:0]       start_y,
	input  logic [glsw_pkg::XY_W-1:0]       end_x,
	input  logic [glsw_pkg::XY_W-1:0]       end_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            wall_found
);

	import glsw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	glsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	glsw_dp #(
		.MAP_COLS   (MAP_COLS),
		.MAP_ROWS   (MAP_ROWS),
		.TILE_PIXELS(TILE_PIXELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.tile_index  (tile_index),
		.tile_is_wall(tile_is_wall),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.wall_found  (wall_found)
	);

endmodule

### hdl/glsw_checker.sv
`include "grid_line_of_sight_walker_macros.svh"

module glsw_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic func,
	input logic out_valid,
	input logic out_stall,
	input logic wall_found
);

	`GLSW_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result item dropped")
	`GLSW_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(wall_found), "result changed")
	`GLSW_ASSERT_NXT(a_query_busy, in_valid && !in_stall && func, in_stall, "query not held")
	`GLSW_ASSERT_NXT(a_write_free, in_valid && !in_stall && !func, !in_stall, "write stalled")
	`GLSW_ASSERT_IMP(a_res_busy, $rose(out_valid), $past(in_stall), "result while idle")

endmodule

bind grid_line_of_sight_walker glsw_checker u_chk (.*);

### verif/tb_grid_line_of_sight_walker.sv
module tb_grid_line_of_sight_walker;
	timeunit 1ns;
	timeprecision 1ps;

	import glsw_pkg::*;

	localparam int MAP_COLS    = MAP_COLS_DEF;
	localparam int MAP_ROWS    = MAP_ROWS_DEF;
	localparam int TILE_PIXELS = TILE_PIXELS_DEF;
	localparam int MAP_TILES   = MAP_COLS * MAP_ROWS;
	localparam int N_RANDOM    = 800;
	localparam int N_DIRECTED  = 23;

	localparam bit OP_WRITE = 1'b0;
	localparam bit OP_QUERY = 1'b1;

	typedef struct {
		bit                  op;
		bit [TILE_IDX_W-1:0] idx;
		bit                  wall;
		bit [XY_W-1:0]       sx;
		bit [XY_W-1:0]       sy;
		bit [XY_W-1:0]       ex;
		bit [XY_W-1:0]       ey;
		bit                  typed;
		bit                  want;
	} sight_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  func = OP_WRITE;
	logic [TILE_IDX_W-1:0] tile_index = '0;
	logic                  tile_is_wall = 1'b0;
	logic [XY_W-1:0]       start_x = '0;
	logic [XY_W-1:0]       start_y = '0;
	logic [XY_W-1:0]       end_x = '0;
	logic [XY_W-1:0]       end_y = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  wall_found;

	bit wall_tiles [MAP_TILES];
	bit blocked_q [$];
	int fail_count;
	bit idle_on = 1'b1;
	bit stall_on = 1'b1;
	int hold_ask;
	int hold_served;
	int hold_left;
	bit want_now;

	sight_row_t dir_rows [N_DIRECTED] = '{
		'{OP_QUERY, 12'd0,    1'b0, 11'd0,    11'd0,    11'd2047, 11'd2047, 1'b1, 1'b0},
		'{OP_QUERY, 12'd0,    1'b0, 11'd2047, 11'd2047, 11'd0,    11'd0,    1'b1, 1'b0},
		'{OP_WRITE, 12'd0,    1'b1, 11'd0,    11'd0,    11'd0,    11'd0,    1'b0, 1'b0},
		'{OP_QUERY, 12'd4095, 1'b1, 11'd0,    11'd0,    11'd0,    11'd0,    1'b1, 1'b1},
		'{OP_QUERY, 12'd0,    1'b0, 11'd40,   11'd0,    11'd40,   11'd0,    1'b1, 1'b0},
		'{OP_WRITE, 12'd4095, 1'b1, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 1'b0, 1'b0},
		'{OP_QUERY, 12'd0,    1'b0, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 1'b1, 1'b1},
		'{OP_QUERY, 12'd0,    1'b0, 11'd0,    11'd2047, 11'd2047, 11'd2047, 1'b0, 1'b0},
		'{OP_QUERY, 12'd0,    1'b0, 11'd2047, 11'd0,    11'd2047, 11'd2047, 1'b0, 1'b0},
		'{OP_QUERY, 12'd0,    1'b0, 11'd0,    11'd0,    11'd2047, 11'd2047, 1'b0, 1'b0},
		'{OP_WRITE, 12'd4095, 1'b0, 11'd0,    11'd0,    11'd0,    11'd0,    1'b0, 1'b0},
		'{OP_WRITE, 12'd0,    1'b0, 11'd0,    11'd0,    11'd0,    11'd0,    1'b0, 1'b0},
		'{OP_WRITE, 12'd1,    1'b1, 11'd0,    11'd0,    11'd0,    11'd0,    1'b0, 1'b0},
		'{OP_QUERY, 12'd0,    1'b0, 11'd16,   11'd16,   11'd40,   11'd40,   1'b0, 1'b0},
		'{OP_QUERY, 12'd0,    1'b0, 11'd40,   11'd40,   11'd16,   11'd16,   1'b0, 1'b0},
		'{OP_WRITE, 12'd63,   1'b1, 11'd0,    11'd0,    11'd0,    11'd0,    1'b0, 1'b0},
		'{OP_QUERY, 12'd0,    1'b0, 11'd0,    11'd0,    11'd2047, 11'd0,    1'b0, 1'b0},
		'{OP_QUERY, 12'd0,    1'b0, 11'd2047, 11'd31,   11'd0,    11'd31,   1'b0, 1'b0},
		'{OP_QUERY, 12'd0,    1'b0, 11'd64,   11'd64,   11'd0,    11'd64,   1'b0, 1'b0},
		'{OP_QUERY, 12'd0,    1'b0, 11'd2016, 11'd0,    11'd2016, 11'd2047, 1'b0, 1'b0},
		'{OP_WRITE, 12'd1,    1'b0, 11'd0,    11'd0,    11'd0,    11'd0,    1'b0, 1'b0},
		'{OP_WRITE, 12'd63,   1'b0, 11'd0,    11'd0,    11'd0,    11'd0,    1'b0, 1'b0},
		'{OP_QUERY, 12'd0,    1'b0, 11'd1000, 11'd1000, 11'd1000, 11'd1000, 1'b1, 1'b0}
	};

	grid_line_of_sight_walker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.tile_index   (tile_index),
		.tile_is_wall (tile_is_wall),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.wall_found   (wall_found)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// walk the tiles crossed by the segment, nearer border first, ties go to x
	function automatic bit sight_blocked(input int unsigned sx, sy, ex, ey);
		int unsigned tx, ty, adx, ady, bx, by, crossed, tile;
		bit          xfwd, yfwd, horiz;
		tx = sx / TILE_PIXELS;
		ty = sy / TILE_PIXELS;
		if (tx >= MAP_COLS || ty >= MAP_ROWS)
			return 1'b1;
		adx  = (ex >= sx) ? ex - sx : sx - ex;
		ady  = (ey >= sy) ? ey - sy : sy - ey;
		xfwd = ex > sx;
		yfwd = ey > sy;
		bx   = xfwd ? tx * TILE_PIXELS + TILE_PIXELS - sx : sx - tx * TILE_PIXELS;
		by   = yfwd ? ty * TILE_PIXELS + TILE_PIXELS - sy : sy - ty * TILE_PIXELS;
		tile = ty * MAP_COLS + tx;
		while (1) begin
			if (wall_tiles[tile])
				return 1'b1;
			if (adx == 0 && ady == 0)
				return 1'b0;
			horiz = (ady == 0) ||
				(adx != 0 && longint'(bx) * longint'(ady) <= longint'(by) * longint'(adx));
			if (horiz) begin
				crossed = bx;
				bx += TILE_PIXELS;
				if (crossed >= adx)
					return 1'b0;
				if (xfwd)
					tile = (tile + 1 >= MAP_TILES) ? tile : tile + 1;
				else
					tile = (tile == 0) ? tile : tile - 1;
			end else begin
				crossed = by;
				by += TILE_PIXELS;
				if (crossed >= ady)
					return 1'b0;
				if (yfwd)
					tile = (tile + MAP_COLS >= MAP_TILES) ? tile : tile + MAP_COLS;
				else
					tile = (tile < MAP_COLS) ? tile : tile - MAP_COLS;
			end
		end
	endfunction

	function automatic bit [XY_W-1:0] nearby(input int base);
		int v;
		v = base + int'($urandom_range(400)) - 200;
		if (v < 0)
			v = 0;
		if (v > 2047)
			v = 2047;
		return XY_W'(v);
	endfunction

	task automatic roll_item(output bit op, output bit [TILE_IDX_W-1:0] idx, output bit wall,
			output bit [XY_W-1:0] sx, sy, ex, ey);
		int unsigned shape;
		bit          corner;
		op     = ($urandom_range(99) < 40) ? OP_WRITE : OP_QUERY;
		corner = 1'($urandom_range(1));
		idx    = TILE_IDX_W'($urandom);
		wall   = $urandom_range(99) < 35;
		sx     = XY_W'($urandom);
		sy     = XY_W'($urandom);
		ex     = XY_W'($urandom);
		ey     = XY_W'($urandom);
		if (op == OP_WRITE) begin
			if (corner)
				idx = TILE_IDX_W'($urandom_range(15) * MAP_COLS + $urandom_range(15));
		end else begin
			if (corner) begin
				sx = XY_W'($urandom_range(511));
				sy = XY_W'($urandom_range(511));
			end
			shape = $urandom_range(9);
			if (shape < 5) begin
				ex = nearby(sx);
				ey = nearby(sy);
			end else if (shape == 7) begin
				ey = sy;
			end else if (shape == 8) begin
				ex = sx;
			end else if (shape == 9) begin
				sx[4:0] = '0;
				sy[4:0] = '0;
				if ($urandom_range(1)) begin
					ex = sx;
					ey = sy;
				end else begin
					ex = nearby(sx);
					ey = nearby(sy);
				end
			end
		end
	endtask

	task automatic send_item(input bit op, input bit [TILE_IDX_W-1:0] idx, input bit wall,
			input bit [XY_W-1:0] sx, sy, ex, ey, input bit typed, input bit want);
		if (idle_on && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		func         <= op;
		tile_index   <= idx;
		tile_is_wall <= wall;
		start_x      <= sx;
		start_y      <= sy;
		end_x        <= ex;
		end_y        <= ey;
		in_valid     <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		if (op == OP_WRITE) begin
			if (int'(idx) < MAP_TILES)
				wall_tiles[idx] = wall;
		end else begin
			blocked_q = {blocked_q, (typed ? want : sight_blocked(sx, sy, ex, ey))};
		end
	endtask

	initial begin
		bit                  op, wall;
		bit [TILE_IDX_W-1:0] idx;
		bit [XY_W-1:0]       sx, sy, ex, ey;
		wait (arst_n);
		@(posedge clk);
		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].wall, dir_rows[i].sx,
				dir_rows[i].sy, dir_rows[i].ex, dir_rows[i].ey, dir_rows[i].typed,
				dir_rows[i].want);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 100)
				hold_ask <= hold_ask + 1;
			if (n == 300) begin
				idle_on  = 1'b0;
				stall_on = 1'b0;
			end
			if (n == 500) begin
				idle_on  = 1'b1;
				stall_on = 1'b1;
			end
			if (n == 600) begin
				in_valid <= 1'b0;
				while (blocked_q.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end
			roll_item(op, idx, wall, sx, sy, ex, ey);
			send_item(op, idx, wall, sx, sy, ex, ey, 1'b0, 1'b0);
		end
		in_valid <= 1'b0;
		while (blocked_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// hold off the result side for a long stretch when asked
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_served != hold_ask) begin
			hold_served <= hold_ask;
			hold_left   <= 400;
			out_stall   <= 1'b1;
		end else begin
			out_stall <= stall_on && ($urandom_range(99) < 17);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (blocked_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: wall_found=%0b", wall_found);
			end else begin
				want_now = blocked_q.pop_front();
				if (wall_found !== want_now) begin
					fail_count++;
					if (fail_count <= 10)
						$display("wall_found mismatch: expected %0b, got %0b",
							want_now, wall_found);
				end
			end
		end
	end

endmodule
